// ----- rtl/ordered_mask_rule_table_unit_assert.svh -----
// Assertion macros for the rule table unit.
// OMRT_ASSERT checks a property that is disabled while reset is high.
// OMRT_ASSERT_NORST checks a property at every clock edge, reset included.
`ifndef ORDERED_MASK_RULE_TABLE_UNIT_ASSERT_SVH
`define ORDERED_MASK_RULE_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define OMRT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("omrt assertion failed");
`define OMRT_ASSERT_NORST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("omrt assertion failed");
`else
`define OMRT_ASSERT(lbl, clk, rst, prop)
`define OMRT_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ----- rtl/omrt_pkg.sv -----
package omrt_pkg;

   localparam int ACTION_W  = 3;
   localparam int POS_W     = 5;
   localparam int MASK_W    = 32;
   localparam int PAY_W     = 64;
   localparam int STATUS_W  = 3;
   localparam int INDEX_W   = 4;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_STRIP  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_DECIDE,
      S_DONE
   } state_type;

   // what each cell does with its entry of the selected list
   typedef enum logic [1:0] {
      CM_HOLD,
      CM_INSERT,
      CM_REMOVE,
      CM_STRIP
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      logic          list;
   } cell_cmd_type;

   typedef struct packed {
      logic covered;
      logic overlap;
      logic empties;
   } cell_flags_type;

endpackage

// ----- rtl/omrt_if.sv -----
interface omrt_req_if
   import omrt_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic                list_select;
   logic [POS_W-1:0]    position;
   logic [MASK_W-1:0]   bearer_mask;
   logic [PAY_W-1:0]    payload_in;

   modport source (output valid, action, list_select, position, bearer_mask, payload_in,
                   input ready);
   modport sink (input valid, action, list_select, position, bearer_mask, payload_in,
                 output ready);
endinterface

interface omrt_rsp_if
   import omrt_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [INDEX_W-1:0]  rule_index;
   logic                rule_removed;
   logic [MASK_W-1:0]   bearer_mask_out;
   logic [PAY_W-1:0]    payload_out;

   modport source (output valid, status, rule_index, rule_removed, bearer_mask_out,
                   payload_out, input ready);
   modport sink (input valid, status, rule_index, rule_removed, bearer_mask_out,
                 payload_out, output ready);
endinterface

// ----- rtl/omrt_cell.sv -----
// One rule slot, holding the entry of both lists at this position.
module omrt_cell
   import omrt_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int IW    = 4,
   parameter int CW    = 5,
   parameter int PB    = 64
) (
   input  logic              clock,
   input  cell_cmd_type      cmd,
   input  logic [IW-1:0]     pos,
   input  logic [CW-1:0]     count,
   input  logic [MASK_W-1:0] query_mask,
   input  logic [PB-1:0]     new_pay,
   input  logic [MASK_W-1:0] prev_mask,
   input  logic [PB-1:0]     prev_pay,
   input  logic [MASK_W-1:0] next_mask,
   input  logic [PB-1:0]     next_pay,
   output logic [MASK_W-1:0] mask_out,
   output logic [PB-1:0]     pay_out,
   output cell_flags_type    flags
);

   localparam logic [IW-1:0] ME   = IW'(INDEX);
   localparam logic [CW-1:0] ME_C = CW'(INDEX);

   logic [MASK_W-1:0] mask_ff [2];
   logic [MASK_W-1:0] mask_in [2];
   logic [PB-1:0]     pay_ff  [2];
   logic [PB-1:0]     pay_in  [2];
   logic              occupied;

   always_comb begin
      mask_in = mask_ff;
      pay_in  = pay_ff;
      unique case (cmd.mode)
         CM_INSERT: begin
            if (ME > pos) begin
               mask_in[cmd.list] = prev_mask;
               pay_in[cmd.list]  = prev_pay;
            end else if (ME == pos) begin
               mask_in[cmd.list] = query_mask;
               pay_in[cmd.list]  = new_pay;
            end
         end
         CM_REMOVE: begin
            if (ME >= pos) begin
               mask_in[cmd.list] = next_mask;
               pay_in[cmd.list]  = next_pay;
            end
         end
         CM_STRIP: begin
            if (ME == pos) begin
               mask_in[cmd.list] = mask_ff[cmd.list] & ~query_mask;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      pay_ff  <= pay_in;
   end

   assign mask_out = mask_ff[cmd.list];
   assign pay_out  = pay_ff[cmd.list];
   assign occupied = ME_C < count;

   always_comb begin
      flags.covered = occupied && ((mask_out & query_mask) == query_mask);
      flags.overlap = occupied && ((mask_out & query_mask) != '0);
      flags.empties = occupied && ((mask_out & ~query_mask) == '0);
   end

endmodule

// ----- rtl/ordered_mask_rule_table_unit.sv -----
// Ordered bearer-mask rule table: two rule lists (inbox, other folders),
// each an ordered list of up to MAX_RULES nonzero masks with a payload.
// req_ch carries one request (action, list, position, mask, payload);
// rsp_ch returns exactly one response per request, in order. Both are
// valid/ready channels; a transfer happens when valid and ready are high.
// rsp valid rises after the request passes through per-cell compare,
// decide/apply and response load (S_EVAL, S_DECIDE, S_DONE). The next
// request is taken only after the response is loaded, so one request
// is worked on at a time; S_DONE holds while rsp_ch.ready is low and
// an earlier response still waits in the output register.
// Rules live in a chain of cells, one per position; insert and delete move
// entries one cell along the chain together.
// A finished response waits in the output register while the next request
// is accepted and worked on; a stalled receiver holds the pipeline only
// when a second response is ready to be loaded.
// Reset (synchronous, active high) empties both lists; rule storage itself
// is not cleared, entries beyond a list's count are never looked at.
`include "ordered_mask_rule_table_unit_assert.svh"

module ordered_mask_rule_table_unit
   import omrt_pkg::*;
#(
   parameter int MAX_RULES    = 16,
   parameter int PAYLOAD_BITS = 64
) (
   input  logic       clock,
   input  logic       reset,
   omrt_req_if.sink   req_ch,
   omrt_rsp_if.source rsp_ch
);

   localparam int IW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int CW = $clog2(MAX_RULES + 1);
   localparam int PB = PAYLOAD_BITS;

   // FSM
   state_type state_ff, state_in;
   logic      eval_en, decide_en, done_load;

   // captured request
   logic [ACTION_W-1:0] action_ff;
   logic                list_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [MASK_W-1:0]   qmask_ff;
   logic [PB-1:0]       pay_ff;

   // list fill counts
   logic [CW-1:0] count_ff [2];
   logic [CW-1:0] count_in [2];

   // registered cell compare results
   logic [MAX_RULES-1:0] cover_ff, overlap_ff, empty_ff;

   // decision results
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                removed_ff, removed_in;
   logic                want_mask_ff, want_mask_in;
   logic                want_pay_ff, want_pay_in;

   // response register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic                rsp_removed_ff;
   logic [MASK_W-1:0]   rsp_mask_ff;
   logic [PAY_W-1:0]    rsp_pay_ff;

   // cell row
   cell_cmd_type   cmd;
   cell_mode_type  mode_dec;
   logic [IW-1:0]  cpos;
   logic [CW-1:0]  n;
   logic [MASK_W-1:0] cell_mask [MAX_RULES];
   logic [PB-1:0]     cell_pay  [MAX_RULES];
   cell_flags_type    cell_flags [MAX_RULES];

   // decode helpers
   logic          pos_bad, pos_ge_n, full, any_ov, found, mask_zero;
   logic [IW-1:0] fidx, ins_pos;

   //------------------------------------------------------------------
   // State machine
   //------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_ch.valid) state_in = S_EVAL;
         S_EVAL:   state_in = S_DECIDE;
         S_DECIDE: state_in = S_DONE;
         S_DONE:   if (!rsp_valid_ff || rsp_ch.ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // no request is taken while reset is high
   always_comb begin
      req_ch.ready = 1'b0;
      eval_en      = 1'b0;
      decide_en    = 1'b0;
      done_load    = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_ch.ready = !reset;
         S_EVAL:   eval_en = 1'b1;
         S_DECIDE: decide_en = 1'b1;
         S_DONE:   done_load = !rsp_valid_ff || rsp_ch.ready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture; payload keeps its low PAYLOAD_BITS bits
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         action_ff <= req_ch.action;
         list_ff   <= req_ch.list_select;
         pos_ff    <= req_ch.position;
         qmask_ff  <= req_ch.bearer_mask;
         pay_ff    <= req_ch.payload_in[PB-1:0];
      end
   end

   //------------------------------------------------------------------
   // Cell chain: each cell shifts with its neighbors on insert/remove
   //------------------------------------------------------------------
   assign n = count_ff[list_ff];

   always_comb begin
      cmd.list = list_ff;
      cmd.mode = decide_en ? mode_dec : CM_HOLD;
   end

   for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
      logic [MASK_W-1:0] pm, nm;
      logic [PB-1:0]     pp, np;

      if (i == 0) begin : g_first
         assign pm = '0;
         assign pp = '0;
      end else begin : g_prev
         assign pm = cell_mask[i-1];
         assign pp = cell_pay[i-1];
      end

      if (i == MAX_RULES - 1) begin : g_last
         assign nm = '0;
         assign np = '0;
      end else begin : g_next
         assign nm = cell_mask[i+1];
         assign np = cell_pay[i+1];
      end

      omrt_cell #(
         .INDEX (i),
         .IW    (IW),
         .CW    (CW),
         .PB    (PB)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos        (cpos),
         .count      (n),
         .query_mask (qmask_ff),
         .new_pay    (pay_ff),
         .prev_mask  (pm),
         .prev_pay   (pp),
         .next_mask  (nm),
         .next_pay   (np),
         .mask_out   (cell_mask[i]),
         .pay_out    (cell_pay[i]),
         .flags      (cell_flags[i])
      );
   end

   always_ff @(posedge clock) begin
      if (eval_en) begin
         for (int i = 0; i < MAX_RULES; i++) begin
            cover_ff[i]   <= cell_flags[i].covered;
            overlap_ff[i] <= cell_flags[i].overlap;
            empty_ff[i]   <= cell_flags[i].empties;
         end
      end
   end

   //------------------------------------------------------------------
   // Decide: status, index and cell command
   //------------------------------------------------------------------
   always_comb begin
      found = 1'b0;
      fidx  = '0;
      // lowest covering position wins
      for (int i = MAX_RULES - 1; i >= 0; i--) begin
         if (cover_ff[i]) begin
            found = 1'b1;
            fidx  = IW'(i);
         end
      end
   end

   assign any_ov    = |overlap_ff;
   assign mask_zero = (qmask_ff == '0);
   assign pos_bad   = 32'(pos_ff) >= 32'(MAX_RULES);
   assign pos_ge_n  = 32'(pos_ff) >= 32'(n);
   assign full      = n >= CW'(MAX_RULES);
   assign ins_pos   = pos_ge_n ? IW'(n) : IW'(pos_ff);

   always_comb begin
      status_in    = ST_OK;
      idx_in       = '0;
      removed_in   = 1'b0;
      want_mask_in = 1'b0;
      want_pay_in  = 1'b0;
      mode_dec     = CM_HOLD;
      cpos         = '0;
      count_in     = count_ff;
      unique case (action_ff)
         ACT_ADD: begin
            if (pos_bad || mask_zero) begin
               status_in = ST_INVALID;
            end else if (full) begin
               status_in = ST_FULL;
            end else if (any_ov) begin
               status_in = ST_OVERLAP;
            end else begin
               mode_dec          = CM_INSERT;
               cpos              = ins_pos;
               idx_in            = ins_pos;
               count_in[list_ff] = n + CW'(1);
            end
         end
         ACT_DELETE: begin
            if (pos_bad) begin
               status_in = ST_INVALID;
            end else if (pos_ge_n) begin
               status_in = ST_NOTFOUND;
            end else begin
               mode_dec          = CM_REMOVE;
               cpos              = IW'(pos_ff);
               idx_in            = IW'(pos_ff);
               count_in[list_ff] = n - CW'(1);
            end
         end
         ACT_STRIP: begin
            if (mask_zero) begin
               status_in = ST_INVALID;
            end else if (!found) begin
               status_in = ST_NOTFOUND;
            end else begin
               idx_in = fidx;
               cpos   = fidx;
               // mask goes empty: drop the rule like a delete
               if (empty_ff[fidx]) begin
                  mode_dec          = CM_REMOVE;
                  removed_in        = 1'b1;
                  count_in[list_ff] = n - CW'(1);
               end else begin
                  mode_dec = CM_STRIP;
               end
            end
         end
         ACT_READ: begin
            if (pos_bad) begin
               status_in = ST_INVALID;
            end else if (pos_ge_n) begin
               status_in = ST_NOTFOUND;
            end else begin
               idx_in       = IW'(pos_ff);
               want_mask_in = 1'b1;
               want_pay_in  = 1'b1;
            end
         end
         ACT_LOOKUP: begin
            if (mask_zero) begin
               status_in = ST_INVALID;
            end else if (!found) begin
               status_in = ST_NOTFOUND;
            end else begin
               idx_in      = fidx;
               want_pay_in = 1'b1;
            end
         end
         ACT_CLEAR: begin
            count_in[0] = '0;
            count_in[1] = '0;
         end
         default: begin
            status_in = ST_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff[0] <= '0;
         count_ff[1] <= '0;
      end else if (decide_en) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (decide_en) begin
         status_ff    <= status_in;
         idx_ff       <= idx_in;
         removed_ff   <= removed_in;
         want_mask_ff <= want_mask_in;
         want_pay_ff  <= want_pay_in;
      end
   end

   //------------------------------------------------------------------
   // Response register; read and lookup leave the cells untouched, so
   // the selected cell is read here after the decide step
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_load) begin
         rsp_status_ff  <= status_ff;
         rsp_index_ff   <= INDEX_W'(idx_ff);
         rsp_removed_ff <= removed_ff;
         rsp_mask_ff    <= want_mask_ff ? cell_mask[idx_ff] : '0;
         rsp_pay_ff     <= want_pay_ff ? PAY_W'(cell_pay[idx_ff]) : '0;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.rule_index      = rsp_index_ff;
   assign rsp_ch.rule_removed    = rsp_removed_ff;
   assign rsp_ch.bearer_mask_out = rsp_mask_ff;
   assign rsp_ch.payload_out     = rsp_pay_ff;

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   logic            counts_in_range;
   logic [2*CW-1:0] counts_flat;

   assign counts_in_range = (count_ff[0] <= CW'(MAX_RULES)) && (count_ff[1] <= CW'(MAX_RULES));
   assign counts_flat     = {count_ff[1], count_ff[0]};

   `OMRT_ASSERT(a_count_bound, clock, reset, counts_in_range)
   `OMRT_ASSERT(a_count_only_decide, clock, reset, (state_ff != S_DECIDE) |=> $stable(counts_flat))
   `OMRT_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
   `OMRT_ASSERT(a_removed_ok, clock, reset, (rsp_valid_ff && rsp_removed_ff) |-> (rsp_status_ff == ST_OK))
   `OMRT_ASSERT_NORST(a_no_take_in_reset, clock, reset |-> !req_ch.ready)

endmodule
